FILE: hdl/dstui_pkg.sv
// ----------------------------------------------------------------------------
// dstui_pkg: shared types and constants
// Field widths, limit bounds, register indexes and the limit clamp used
// across the dual-setpoint thermostat user interface.
// ----------------------------------------------------------------------------
package dstui_pkg;

	localparam int LIMIT_W = 8;
	localparam int TEMP_W  = 11;
	localparam int COUNT_W = 9;
	localparam int DEB_W   = 8;
	localparam int IDX_W   = 2;

	localparam logic [DEB_W-1:0]          DEBOUNCE_RESET = 8'd25;
	localparam logic signed [LIMIT_W-1:0] SAVED_RESET    = 8'sd0;
	localparam logic signed [LIMIT_W-1:0] LIMIT_MIN      = -8'sd40;
	localparam logic signed [LIMIT_W-1:0] LIMIT_MAX      = 8'sd125;
	localparam logic [COUNT_W-1:0]        QUIET_MAX      = 9'd511;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAVED_UPPER = 2'd1;
	localparam logic [IDX_W-1:0] REG_SAVED_LOWER = 2'd2;

	// limit selection codes
	localparam logic [1:0] SEL_NONE  = 2'd0;
	localparam logic [1:0] SEL_UPPER = 2'd1;
	localparam logic [1:0] SEL_LOWER = 2'd2;

	typedef struct packed {
		logic                      we;
		logic [IDX_W-1:0]          index;
		logic [DEB_W-1:0]          data;
	} cfg_wr_t;

	typedef struct packed {
		logic       advance;
		logic       enc_a;
		logic       enc_b;
		logic [1:0] chosen;
	} enc_ctl_t;

	function automatic logic signed [LIMIT_W-1:0] clamp_limit(
		input logic signed [LIMIT_W:0] v
	);
		logic signed [LIMIT_W:0] lo;
		logic signed [LIMIT_W:0] hi;
		lo = {LIMIT_MIN[LIMIT_W-1], LIMIT_MIN};
		hi = {LIMIT_MAX[LIMIT_W-1], LIMIT_MAX};
		if (v < lo) begin
			clamp_limit = LIMIT_MIN;
		end else if (v > hi) begin
			clamp_limit = LIMIT_MAX;
		end else begin
			clamp_limit = v[LIMIT_W-1:0];
		end
	endfunction

endpackage

FILE: hdl/dual_setpoint_thermostat_ui.sv
// ----------------------------------------------------------------------------
// dual_setpoint_thermostat_ui: thermostat menu, setpoints and relays
// Debounced mode/select buttons drive the edit menu, the encoder steps the
// chosen limit and two relays compare each sample against the limits.
//
//   channel  dir  handshake                     content
//   s_axis   in   s_axis_tvalid/s_axis_tready   one tick of buttons, encoder, sample
//   m_axis   out  m_axis_tvalid/m_axis_tready   relays, limits, menu state, save
//   cfg      in   cfg_we                        debounce ticks, saved limits
//
// One transaction per cycle sustained while the output is not stalled; each result
// passes through the input register, then the result register.
// Reset clears the debouncers and menu, loads the limits with 0 and the
// debounce count with 25.
// A stalled output holds the result; the input register keeps taking a
// transaction as long as the result register can move.
// ----------------------------------------------------------------------------
module dual_setpoint_thermostat_ui
	import dstui_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [0] mode_button, [1] select_button, [2] enc_a, [3] enc_b, [14:4] temperature,
	// [15] zero
	input  logic [15:0]      s_axis_tdata,
	// [0] temp_valid
	input  logic             s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [0] over_relay, [1] under_relay, [9:2] upper_limit, [17:10] lower_limit,
	// [18] edit_mode, [20:19] selected_limit, [21] save_strobe, [23:22] zero
	output logic [23:0]      m_axis_tdata,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DEB_W-1:0] cfg_data
);

	logic [DEB_W-1:0] debounce_q;

	logic                     valid_s1;
	logic [15:0]              data_s1;
	logic                     tvalid_s1;
	logic                     valid_s2;
	logic [23:0]              data_s2;

	logic                      advance;
	logic                      mode_press;
	logic                      select_press;
	logic                      editing_q;
	logic [1:0]                chosen_q;
	logic                      editing_next;
	logic [1:0]                chosen_next;
	logic                      save;
	logic signed [LIMIT_W-1:0] upper_next;
	logic signed [LIMIT_W-1:0] lower_next;
	logic signed [TEMP_W-1:0]  temp_s1;
	logic signed [11:0]        temp_ext;
	logic signed [11:0]        upper_ext;
	logic signed [11:0]        lower_ext;
	logic signed [11:0]        upper_x10;
	logic signed [11:0]        lower_x10;
	logic                      over;
	logic                      under;
	cfg_wr_t                   cfg;
	enc_ctl_t                  ctl;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};
	assign ctl = '{advance: advance, enc_a: data_s1[2], enc_b: data_s1[3], chosen: chosen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we && cfg_index == REG_DEBOUNCE) begin
			debounce_q <= cfg_data;
		end
	end

	dstui_debounce u_mode_deb (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.raw     (data_s1[0]),
		.ticks   (debounce_q),
		.press   (mode_press)
	);

	dstui_debounce u_select_deb (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.raw     (data_s1[1]),
		.ticks   (debounce_q),
		.press   (select_press)
	);

	dstui_limits u_limits (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg        (cfg),
		.upper_next (upper_next),
		.lower_next (lower_next)
	);

	always_comb begin
		editing_next = mode_press ? !editing_q : editing_q;
		save         = mode_press && editing_q;
		if (select_press) begin
			chosen_next = (chosen_q == SEL_LOWER) ? SEL_NONE : chosen_q + 2'd1;
		end else begin
			chosen_next = chosen_q;
		end

		// compare in tenths: limit * 10 = limit * 8 + limit * 2
		temp_s1   = data_s1[14:4];
		temp_ext  = {temp_s1[TEMP_W-1], temp_s1};
		upper_ext = {{4{upper_next[LIMIT_W-1]}}, upper_next};
		lower_ext = {{4{lower_next[LIMIT_W-1]}}, lower_next};
		upper_x10 = (upper_ext <<< 3) + (upper_ext <<< 1);
		lower_x10 = (lower_ext <<< 3) + (lower_ext <<< 1);
		over      = tvalid_s1 && (temp_ext > upper_x10);
		under     = tvalid_s1 && (temp_ext < lower_x10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			editing_q <= 1'b0;
			chosen_q  <= SEL_NONE;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2  <= 1'b1;
				editing_q <= editing_next;
				chosen_q  <= chosen_next;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1   <= s_axis_tdata;
			tvalid_s1 <= s_axis_tuser;
		end
		if (advance) begin
			data_s2 <= {2'b00, save, chosen_next, editing_next, lower_next, upper_next,
				under, over};
		end
	end

	a_save_leaves_edit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[21] |-> !m_axis_tdata[18])
		else $error("save strobe while still editing");

	a_sel_code: assert property (@(posedge clk) disable iff (!arst_n)
		chosen_q != 2'd3)
		else $error("selected limit code out of range");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input blocked without a full pipeline");

	a_save_needs_edit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && save |-> editing_q && mode_press)
		else $error("save strobe outside edit mode");

endmodule

FILE: hdl/dstui_debounce.sv
// ----------------------------------------------------------------------------
// dstui_debounce: button debouncer
// Counts ticks of an unchanged raw level and flags a newly accepted press.
// ----------------------------------------------------------------------------
module dstui_debounce
	import dstui_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             raw,
	input  logic [DEB_W-1:0] ticks,
	output logic             press
);

	logic               stable_q;
	logic               prev_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               accept;

	always_comb begin
		if (raw != prev_q) begin
			count_next = '0;
		end else if (count_q != QUIET_MAX) begin
			count_next = count_q + 1'b1;
		end else begin
			count_next = count_q;
		end
		accept = (count_next > {1'b0, ticks}) && (raw != stable_q);
		press  = accept && !raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			prev_q   <= 1'b1;
			count_q  <= '0;
		end else if (advance) begin
			prev_q  <= raw;
			count_q <= count_next;
			if (accept) begin
				stable_q <= raw;
			end
		end
	end

endmodule

FILE: hdl/dstui_limits.sv
// ----------------------------------------------------------------------------
// dstui_limits: setpoint registers
// Holds the upper and lower limits, steps the chosen one on a rising
// encoder clock and reloads them from saved-value register writes.
// ----------------------------------------------------------------------------
module dstui_limits
	import dstui_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  enc_ctl_t                  ctl,
	input  cfg_wr_t                   cfg,
	output logic signed [LIMIT_W-1:0] upper_next,
	output logic signed [LIMIT_W-1:0] lower_next
);

	logic                      last_a_q;
	logic signed [LIMIT_W-1:0] upper_q;
	logic signed [LIMIT_W-1:0] lower_q;
	logic                      rising;
	logic signed [LIMIT_W:0]   delta;
	logic signed [LIMIT_W:0]   upper_sum;
	logic signed [LIMIT_W:0]   lower_sum;

	always_comb begin
		rising    = ctl.enc_a && !last_a_q;
		// data line different from clock line raises the limit
		delta     = (ctl.enc_b != ctl.enc_a) ? 9'sd1 : -9'sd1;
		upper_sum = {upper_q[LIMIT_W-1], upper_q} + delta;
		lower_sum = {lower_q[LIMIT_W-1], lower_q} + delta;
		upper_next = (rising && ctl.chosen == SEL_UPPER) ? clamp_limit(upper_sum) : upper_q;
		lower_next = (rising && ctl.chosen == SEL_LOWER) ? clamp_limit(lower_sum) : lower_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
			upper_q  <= SAVED_RESET;
			lower_q  <= SAVED_RESET;
		end else begin
			if (cfg.we && cfg.index == REG_SAVED_UPPER) begin
				upper_q <= clamp_limit({cfg.data[LIMIT_W-1], cfg.data});
			end else if (ctl.advance) begin
				upper_q <= upper_next;
			end
			if (cfg.we && cfg.index == REG_SAVED_LOWER) begin
				lower_q <= clamp_limit({cfg.data[LIMIT_W-1], cfg.data});
			end else if (ctl.advance) begin
				lower_q <= lower_next;
			end
			if (ctl.advance) begin
				last_a_q <= ctl.enc_a;
			end
		end
	end

	a_upper_range: assert property (@(posedge clk) disable iff (!arst_n)
		upper_q >= LIMIT_MIN && upper_q <= LIMIT_MAX)
		else $error("upper limit out of range");

	a_lower_range: assert property (@(posedge clk) disable iff (!arst_n)
		lower_q >= LIMIT_MIN && lower_q <= LIMIT_MAX)
		else $error("lower limit out of range");

	a_no_step_unselected: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance && ctl.chosen == SEL_NONE && !cfg.we
		|=> $stable(upper_q) && $stable(lower_q))
		else $error("limit moved with no limit selected");

endmodule

FILE: dv/tb_dual_setpoint_thermostat_ui.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_setpoint_thermostat_ui: self-checking bench for the thermostat menu
// Streams sampling ticks into the block with random gaps and output stalls.
// A scoreboard class mirrors the debouncers, menu, limits and relays, and
// compares every result field by field. Configuration changes between phases
// cover debounce extremes and out-of-range saved limits.
// ----------------------------------------------------------------------------
module tb_dual_setpoint_thermostat_ui;
	import dstui_pkg::*;

	localparam int GAP_MAX     = 17;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic                      mode_btn;
		logic                      sel_btn;
		logic                      enc_a;
		logic                      enc_b;
		logic signed [TEMP_W-1:0]  temp;
		logic                      temp_ok;
	} tick_t;

	typedef struct packed {
		logic                      over;
		logic                      under;
		logic signed [LIMIT_W-1:0] upper;
		logic signed [LIMIT_W-1:0] lower;
		logic                      edit;
		logic [1:0]                sel;
		logic                      save;
	} reading_t;

	class thermostat_mirror;
		logic [DEB_W-1:0]          deb_ticks;
		logic signed [LIMIT_W-1:0] upper_lim;
		logic signed [LIMIT_W-1:0] lower_lim;
		logic                      editing;
		logic [1:0]                chosen;
		logic                      last_a;
		logic                      btn_stable[2];
		logic                      btn_prev[2];
		int unsigned               btn_quiet[2];
		reading_t                  due[$];
		int                        fails;

		function new();
			deb_ticks = DEBOUNCE_RESET;
			upper_lim = bound(int'(SAVED_RESET));
			lower_lim = bound(int'(SAVED_RESET));
			editing = 1'b0;
			chosen = SEL_NONE;
			last_a = 1'b0;
			for (int k = 0; k < 2; k++) begin
				btn_stable[k] = 1'b1;
				btn_prev[k] = 1'b1;
				btn_quiet[k] = 0;
			end
			fails = 0;
		endfunction

		function logic signed [LIMIT_W-1:0] bound(int v);
			if (v < int'(LIMIT_MIN)) return LIMIT_MIN;
			if (v > int'(LIMIT_MAX)) return LIMIT_MAX;
			return v[LIMIT_W-1:0];
		endfunction

		function void load_register(logic [IDX_W-1:0] idx, logic [DEB_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: begin
					deb_ticks = val;
				end
				REG_SAVED_UPPER: begin
					upper_lim = bound(int'($signed(val)));
				end
				REG_SAVED_LOWER: begin
					lower_lim = bound(int'($signed(val)));
				end
				default: begin
				end
			endcase
		endfunction

		// button 0 is mode, 1 is select; returns 1 on a newly accepted press
		function logic pressed(int k, logic raw);
			logic hit;
			hit = 1'b0;
			if (raw != btn_prev[k]) btn_quiet[k] = 0;
			else if (btn_quiet[k] < QUIET_MAX) btn_quiet[k]++;
			if (btn_quiet[k] > deb_ticks && raw != btn_stable[k]) begin
				btn_stable[k] = raw;
				hit = !raw;
			end
			btn_prev[k] = raw;
			return hit;
		endfunction

		function void log_tick(tick_t t);
			reading_t r;
			int       step;
			// encoder acts before the buttons, so a select press steps the old choice
			if (t.enc_a && !last_a) begin
				step = (t.enc_b != t.enc_a) ? 1 : -1;
				if (chosen == SEL_UPPER) upper_lim = bound(int'(upper_lim) + step);
				else if (chosen == SEL_LOWER) lower_lim = bound(int'(lower_lim) + step);
			end
			last_a = t.enc_a;
			r.save = 1'b0;
			if (pressed(0, t.mode_btn)) begin
				r.save = editing;
				editing = !editing;
			end
			if (pressed(1, t.sel_btn)) chosen = (chosen >= SEL_LOWER) ? SEL_NONE : chosen + 2'd1;
			r.over = t.temp_ok && (int'(t.temp) > 10 * int'(upper_lim));
			r.under = t.temp_ok && (int'(t.temp) < 10 * int'(lower_lim));
			r.upper = upper_lim;
			r.lower = lower_lim;
			r.edit = editing;
			r.sel = chosen;
			due.push_back(r);
		endfunction

		function void mismatch(string field, int want, int got);
			$error("%s: expected %0d, got %0d", field, want, got);
			fails++;
		endfunction

		function void compare_reading(logic [23:0] d);
			reading_t r;
			if (due.size() == 0) begin
				$error("result 0x%h arrived with no tick pending", d);
				fails++;
				return;
			end
			r = due.pop_front();
			if (d[0] !== r.over) mismatch("over_relay", r.over, d[0]);
			if (d[1] !== r.under) mismatch("under_relay", r.under, d[1]);
			if (d[9:2] !== r.upper) mismatch("upper_limit", r.upper, $signed(d[9:2]));
			if (d[17:10] !== r.lower) mismatch("lower_limit", r.lower, $signed(d[17:10]));
			if (d[18] !== r.edit) mismatch("edit_mode", r.edit, d[18]);
			if (d[20:19] !== r.sel) mismatch("selected_limit", r.sel, d[20:19]);
			if (d[21] !== r.save) mismatch("save_strobe", r.save, d[21]);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// [0] mode_button, [1] select_button, [2] enc_a, [3] enc_b, [14:4] temperature,
	// [15] zero
	logic [15:0]      s_axis_tdata = '0;
	// [0] temp_valid
	logic             s_axis_tuser = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// [0] over_relay, [1] under_relay, [9:2] upper_limit, [17:10] lower_limit,
	// [18] edit_mode, [20:19] selected_limit, [21] save_strobe, [23:22] zero
	logic [23:0]      m_axis_tdata;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_DEBOUNCE;
	logic [DEB_W-1:0] cfg_data = '0;

	thermostat_mirror mirror = new();

	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	int   rx_wait = 0;
	int   idle_cycles = 0;

	// random stimulus state: button levels with remaining run, encoder gray phase
	logic mode_lvl = 1'b1;
	logic sel_lvl = 1'b1;
	int   mode_left = 0;
	int   sel_left = 0;
	int   enc_phase = 0;
	int   enc_dir = 1;

	dual_setpoint_thermostat_ui u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// result sink, random output stalls and the no-progress watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
			idle_cycles = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				mirror.compare_reading(m_axis_tdata);
				rx_wait = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
				if (rx_wait > 0) m_axis_tready <= 1'b0;
			end else if (!m_axis_tready) begin
				if (rx_wait > 0) rx_wait--;
				if (rx_wait == 0) m_axis_tready <= 1'b1;
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_tick(tick_t t);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, t.temp, t.enc_b, t.enc_a, t.sel_btn, t.mode_btn};
		s_axis_tuser <= t.temp_ok;
		do @(posedge clk); while (!s_axis_tready);
		mirror.log_tick(t);
	endtask

	task automatic direct(logic m, logic s, logic a, logic b, int temp, logic ok);
		tick_t t;
		t.mode_btn = m;
		t.sel_btn = s;
		t.enc_a = a;
		t.enc_b = b;
		t.temp = temp[TEMP_W-1:0];
		t.temp_ok = ok;
		send_tick(t);
	endtask

	// hold the input side until every pending result has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (mirror.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [DEB_W-1:0] deb, logic [DEB_W-1:0] up,
	                          logic [DEB_W-1:0] lo);
		logic [IDX_W-1:0] idx[3];
		logic [DEB_W-1:0] val[3];
		idx = '{REG_DEBOUNCE, REG_SAVED_UPPER, REG_SAVED_LOWER};
		val = '{deb, up, lo};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			mirror.load_register(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly runs long enough to pass the debouncer, some shorter glitches
	function automatic int run_len();
		int d;
		d = int'(mirror.deb_ticks);
		if ($urandom_range(0, 4) == 0) return $urandom_range(1, d + 1);
		return $urandom_range(d + 2, d + 8);
	endfunction

	task automatic random_tick();
		tick_t t;
		int    temp;
		if (mode_left == 0) begin
			mode_lvl = !mode_lvl;
			mode_left = run_len();
		end
		mode_left--;
		// with a long debounce keep select steady so its quiet count saturates
		if (mirror.deb_ticks < 8'd128) begin
			if (sel_left == 0) begin
				sel_lvl = !sel_lvl;
				sel_left = run_len();
			end
			sel_left--;
		end
		t.mode_btn = mode_lvl;
		t.sel_btn = sel_lvl;
		if ($urandom_range(0, 9) == 0) begin
			t.enc_a = 1'($urandom_range(0, 1));
			t.enc_b = 1'($urandom_range(0, 1));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 19) == 0) enc_dir = -enc_dir;
				enc_phase = (enc_phase + enc_dir) & 3;
			end
			// gray order 00 -> 10 -> 11 -> 01 raises, the reverse lowers
			t.enc_a = (enc_phase == 1) || (enc_phase == 2);
			t.enc_b = (enc_phase == 2) || (enc_phase == 3);
		end
		case ($urandom_range(0, 3))
			0: temp = 10 * int'(mirror.upper_lim) + $urandom_range(0, 2) - 1;
			1: temp = 10 * int'(mirror.lower_lim) + $urandom_range(0, 2) - 1;
			2: temp = $urandom_range(0, 1200) - 400;
			default: temp = $urandom_range(0, 2047) - 1024;
		endcase
		t.temp = temp[TEMP_W-1:0];
		t.temp_ok = ($urandom_range(0, 7) != 0);
		send_tick(t);
	endtask

	initial begin
		int deb_list[7];
		int n;
		logic [DEB_W-1:0] up;
		logic [DEB_W-1:0] lo;
		deb_list = '{1, 3, 0, 2, 6, 255, 4};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: limits at zero, no choice made yet
		direct(1, 1, 0, 0, 1, 1);
		direct(1, 1, 0, 0, -1, 1);
		direct(1, 1, 0, 0, 0, 1);
		direct(1, 1, 1, 0, 0, 0);
		settle();

		// fastest debounce, saved limits beyond range on both sides
		write_regs(8'd0, 8'h7F, 8'h80);
		direct(0, 1, 0, 0, 0, 1);
		direct(0, 1, 0, 0, 0, 1);
		direct(1, 1, 0, 0, 0, 1);
		direct(1, 0, 0, 0, 0, 1);
		direct(1, 0, 0, 0, 0, 1);
		direct(1, 1, 1, 0, 1023, 1);
		direct(1, 1, 0, 0, 1023, 1);
		direct(1, 1, 1, 1, 1023, 1);
		direct(1, 0, 0, 1, 0, 1);
		direct(1, 0, 0, 1, 0, 1);
		direct(1, 1, 1, 1, -1024, 1);
		direct(1, 1, 0, 0, -1024, 1);
		direct(1, 1, 1, 0, -400, 1);
		direct(1, 0, 0, 0, -400, 1);
		direct(1, 0, 0, 0, 0, 1);
		direct(0, 1, 0, 0, 0, 1);
		direct(0, 1, 0, 0, 0, 1);
		direct(1, 1, 0, 0, 800, 1);
		direct(1, 1, 1, 1, -400, 0);
		// single-tick glitch on mode must not register
		direct(0, 1, 0, 0, 0, 1);
		direct(1, 1, 0, 0, 0, 1);
		settle();

		for (int p = 0; p < 7; p++) begin
			up = 8'($urandom_range(0, 255));
			lo = 8'($urandom_range(0, 255));
			if (p == 2) begin
				up = LIMIT_MIN;
				lo = LIMIT_MAX;
			end else if (p == 4) begin
				up = 8'h80;
				lo = 8'h7F;
			end
			tx_quiet = (p % 3 == 1);
			rx_quiet = (p % 3 == 2);
			write_regs(deb_list[p][DEB_W-1:0], up, lo);
			n = (deb_list[p] == 255) ? 560 : 36;
			for (int i = 0; i < n; i++) begin
				random_tick();
				if ($urandom_range(0, 59) == 0) settle();
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mirror.fails == 0 && mirror.due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
